// File: rtl/pulse_length_line_receiver_macros.svh
// Assertion macros used by the pulse-length line receiver checker.
`ifndef PULSE_LENGTH_LINE_RECEIVER_MACROS_SVH
`define PULSE_LENGTH_LINE_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("plr: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("plr: next-cycle check failed");

`endif

// File: rtl/plr_pkg.sv
// Types, constants and the pulse-width classifier of the line receiver.
package plr_pkg;

	localparam int MAX_MSG_BYTES = 5;
	localparam int NUM_BYTES     = 5;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

	localparam logic [63:0] BIT0_LO   = 64'd300000;
	localparam logic [63:0] BIT0_HI   = 64'd700000;
	localparam logic [63:0] BIT1_LO   = 64'd800000;
	localparam logic [63:0] BIT1_HI   = 64'd1200000;
	localparam int          SYNC_BASE = 2000000;
	localparam int          SYNC_STEP = 1000000;
	localparam int          SYNC_TOL  = 300000;
	localparam int          NUM_SYNCS = 5;

	typedef enum logic [1:0] {
		K_BIT0,
		K_BIT1,
		K_SYNC,
		K_BAD
	} edge_kind_t;

	// One classified release edge.
	typedef struct packed {
		edge_kind_t  kind;
		logic [2:0]  size;
	} edge_cls_t;

	function automatic edge_cls_t classify(logic [63:0] dt);
		edge_cls_t  res;
		logic [2:0] sz;
		logic [63:0] lo;
		logic [63:0] hi;
		sz = 3'd0;
		for (int k = 1; k <= NUM_SYNCS; k++) begin
			lo = 64'(SYNC_BASE + (k - 1) * SYNC_STEP - SYNC_TOL);
			hi = 64'(SYNC_BASE + (k - 1) * SYNC_STEP + SYNC_TOL);
			if (sz == 3'd0 && dt >= lo && dt <= hi) begin
				sz = 3'(k);
			end
		end
		res.size = 3'd0;
		if (dt >= BIT0_LO && dt <= BIT0_HI) begin
			res.kind = K_BIT0;
		end else if (dt >= BIT1_LO && dt <= BIT1_HI) begin
			res.kind = K_BIT1;
		end else if (sz != 3'd0 && sz <= 3'(MAX_MSG_BYTES)) begin
			res.kind = K_SYNC;
			res.size = sz;
		end else begin
			res.kind = K_BAD;
		end
		return res;
	endfunction

endpackage

// File: rtl/plr_front.sv
// Front end: takes edge transactions, keeps the active-edge time, classifies releases.
module plr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              line_active,
	input  logic [63:0]       edge_time_ns,
	input  logic              q_full,
	output logic              push,
	output plr_pkg::edge_cls_t push_cls
);
	import plr_pkg::*;

	logic [63:0] start_time_q;
	logic [63:0] dt;
	logic        accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign dt       = edge_time_ns - start_time_q;
	assign push     = accept && !line_active;
	assign push_cls = classify(dt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q <= '0;
		end else if (accept && line_active) begin
			start_time_q <= edge_time_ns;
		end
	end

endmodule

// File: rtl/plr_fifo.sv
// Short queue of classified edges between front and back.
module plr_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  plr_pkg::edge_cls_t push_cls,
	output logic               full,
	input  logic               pop,
	output logic               q_valid,
	output plr_pkg::edge_cls_t pop_cls
);
	import plr_pkg::*;

	edge_cls_t         slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_pop;

	assign full    = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign pop_cls = slot_q[rd_ptr_q];
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/plr_back.sv
// Back end: message state, byte assembly and the output register.
module plr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  plr_pkg::edge_cls_t pop_cls,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         msg_size,
	output logic [7:0]         out_bytes [plr_pkg::NUM_BYTES]
);
	import plr_pkg::*;

	logic [5:0] bits_q, bits_d;
	logic [2:0] exp_q, exp_d;
	logic       idle_q, idle_d;
	logic [7:0] pay_q [NUM_BYTES];
	logic [7:0] pay_d [NUM_BYTES];
	logic       done;
	logic [5:0] target;
	logic [5:0] bits_inc;
	logic       out_valid_q;
	logic [2:0] size_q;
	logic [7:0] byte_q [NUM_BYTES];

	assign pop      = q_valid && (!out_valid_q || !out_stall);
	assign target   = {exp_q, 3'b000};
	assign bits_inc = bits_q + 6'd1;

	always_comb begin
		bits_d = bits_q;
		exp_d  = exp_q;
		idle_d = idle_q;
		pay_d  = pay_q;
		done   = 1'b0;
		case (pop_cls.kind)
			K_BIT0, K_BIT1: begin
				if (!idle_q) begin
					if (bits_q >= target) begin
						idle_d = 1'b1;
						exp_d  = 3'd0;
						bits_d = 6'd0;
					end else begin
						for (int k = 0; k < NUM_BYTES; k++) begin
							if (bits_q[5:3] == 3'(k)) begin
								pay_d[k] = {pay_q[k][6:0], (pop_cls.kind == K_BIT1)};
							end
						end
						bits_d = bits_inc;
						done   = (bits_inc == target);
					end
				end
			end
			K_SYNC: begin
				exp_d  = pop_cls.size;
				bits_d = 6'd0;
				idle_d = 1'b0;
			end
			default: begin
				idle_d = 1'b1;
				exp_d  = 3'd0;
				bits_d = 6'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q      <= '0;
			exp_q       <= '0;
			idle_q      <= 1'b1;
			out_valid_q <= 1'b0;
			for (int k = 0; k < NUM_BYTES; k++) begin
				pay_q[k] <= '0;
			end
		end else begin
			if (pop) begin
				bits_q <= bits_d;
				exp_q  <= exp_d;
				idle_q <= idle_d;
				pay_q  <= pay_d;
			end
			if (pop && done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded only when the output slot is free or draining
	always_ff @(posedge clk) begin
		if (pop && done) begin
			size_q <= exp_d;
			for (int k = 0; k < NUM_BYTES; k++) begin
				byte_q[k] <= (3'(k) < exp_d) ? pay_d[k] : 8'd0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign msg_size  = size_q;
	assign out_bytes = byte_q;

endmodule

// File: rtl/pulse_length_line_receiver.sv
// Top level of the single-wire pulse-length line receiver.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------
//  edge    | in        | in_valid / in_stall  | line_active, edge_time_ns
//  message | out       | out_valid / out_stall| msg_size, byte0..byte4
//
// Takes one edge transaction per cycle; in_stall rises only when the
// four-entry edge queue is full, which happens only while out_stall holds back.
// A completed message reaches the outputs through the edge queue and the output
// register: the queue entry is written at the accepting edge and the output
// register loads when the back end pops that entry.
// Reset (arst_n low) clears the stored edge time, the queue and the message
// state; the receiver then waits for a sync pulse.
//
// Structure: the front end stores the time of each active edge and, for each
// release, subtracts the stored time (modulo 2^64) and sorts the width into
// 0 bit, 1 bit, sync of 1..5 bytes, or out of range. Classified releases wait
// in a short queue. The back end walks the message state one entry per cycle
// and loads a finished message into the output register; it pops the queue
// only when that register is empty or being drained, so results are never overwritten.
module pulse_length_line_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        line_active,
	input  logic [63:0] edge_time_ns,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  msg_size,
	output logic [7:0]  byte0,
	output logic [7:0]  byte1,
	output logic [7:0]  byte2,
	output logic [7:0]  byte3,
	output logic [7:0]  byte4
);
	import plr_pkg::*;

	logic      push;
	edge_cls_t push_cls;
	logic      q_full;
	logic      pop;
	logic      q_valid;
	edge_cls_t pop_cls;
	logic [7:0] out_bytes [NUM_BYTES];

	// edge timing and width classification
	plr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.line_active  (line_active),
		.edge_time_ns (edge_time_ns),
		.q_full       (q_full),
		.push         (push),
		.push_cls     (push_cls)
	);

	// decouples the edge rate from output back-pressure
	plr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cls (push_cls),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.pop_cls  (pop_cls)
	);

	// message assembly and output register
	plr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.pop_cls   (pop_cls),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.msg_size  (msg_size),
		.out_bytes (out_bytes)
	);

	assign byte0 = out_bytes[0];
	assign byte1 = out_bytes[1];
	assign byte2 = out_bytes[2];
	assign byte3 = out_bytes[3];
	assign byte4 = out_bytes[4];

endmodule

// File: rtl/plr_checker.sv
// Port-level checks of the line receiver, bound to the top level.
`include "pulse_length_line_receiver_macros.svh"

module plr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  msg_size,
	input logic [7:0]  byte0,
	input logic [7:0]  byte1,
	input logic [7:0]  byte2,
	input logic [7:0]  byte3,
	input logic [7:0]  byte4
);

	// a stalled message transaction holds its size and its first and last bytes
	`PLR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(msg_size) && $stable(byte0) && $stable(byte4))

	// message size stays within the sync classes
	`PLR_ASSERT_NOW(a_size_range, clk, arst_n, out_valid, msg_size >= 3'd1 && msg_size <= 3'd5)

	// bytes beyond the message size read as zero
	`PLR_ASSERT_NOW(a_tail_zero, clk, arst_n, out_valid, (msg_size >= 3'd2 || byte1 == 8'd0) && (msg_size >= 3'd3 || byte2 == 8'd0) && (msg_size >= 3'd4 || byte3 == 8'd0) && (msg_size >= 3'd5 || byte4 == 8'd0))

	// every message needs a new sync and a full byte of bits, so two never come back to back
	`PLR_ASSERT_NEXT(a_no_burst, clk, arst_n, out_valid && !out_stall, !out_valid)

endmodule

bind pulse_length_line_receiver plr_checker u_plr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.msg_size  (msg_size),
	.byte0     (byte0),
	.byte1     (byte1),
	.byte2     (byte2),
	.byte3     (byte3),
	.byte4     (byte4)
);

// File: tb/pulse_length_line_receiver_test.sv
// Self-checking pulse-length line receiver testbench: directed and random edges vs a local decoder.
`timescale 1ns / 1ps

module pulse_length_line_receiver_test;
	import plr_pkg::*;

	// One edge transaction waiting to be driven. drain_first holds it back
	// until every predicted message has come out.
	typedef struct packed {
		logic        active;
		logic [63:0] stamp;
		logic        drain_first;
	} edge_t;

	// One predicted message.
	typedef struct packed {
		logic [2:0]                 len;
		logic [NUM_BYTES-1:0][7:0]  data;
	} msg_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        line_active = 1'b0;
	logic [63:0] edge_time_ns = 64'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  msg_size;
	logic [7:0]  byte0;
	logic [7:0]  byte1;
	logic [7:0]  byte2;
	logic [7:0]  byte3;
	logic [7:0]  byte4;

	pulse_length_line_receiver u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.line_active  (line_active),
		.edge_time_ns (edge_time_ns),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.msg_size     (msg_size),
		.byte0        (byte0),
		.byte1        (byte1),
		.byte2        (byte2),
		.byte3        (byte3),
		.byte4        (byte4)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Decoder state, mirrors the receiver. Reset happens once, so the
	// declaration values are the reset values.
	// ---------------------------------------------------------------------
	logic [63:0]                last_active_ns = 64'd0;
	logic [5:0]                 bit_count = 6'd0;
	logic [2:0]                 msg_len = 3'd0;
	logic                       waiting_sync = 1'b1;
	logic [NUM_BYTES-1:0][7:0]  shift_bytes = '0;

	msg_t  pending_msgs [$];   // messages predicted but not yet seen
	edge_t edge_queue [$];     // stimulus not yet driven
	edge_t next_edge;
	msg_t  want;

	int    errors = 0;
	int    edges_accepted = 0;
	int    total_edges = 0;
	int    calm_from = 0;
	int    gap_left = 0;
	int    stall_left = 0;
	logic  long_hold_done = 1'b0;
	logic  may_idle;

	// stimulus generator state
	logic [63:0] gen_now = 64'd0;
	logic        gen_drain = 1'b0;
	int          clean_msgs = 0;

	// Random idling only away from the tail, and with every fourth window
	// of 150 transactions left without new gaps or stalls.
	assign may_idle = edges_accepted < calm_from && (edges_accepted / 150) % 4 != 3;

	// Sync size for a width, 0 when the width is no sync at all.
	function automatic int sync_bytes(logic [63:0] w);
		logic [63:0] centre;
		for (int n = 1; n <= MAX_MSG_BYTES; n++) begin
			centre = 64'(SYNC_BASE) + 64'(n - 1) * 64'(SYNC_STEP);
			if (w >= centre - 64'(SYNC_TOL) && w <= centre + 64'(SYNC_TOL)) begin
				return n;
			end
		end
		return 0;
	endfunction

	function automatic void drop_message();
		waiting_sync = 1'b1;
		msg_len = 3'd0;
		bit_count = 6'd0;
	endfunction

	// Advances the decoder by one accepted edge; queues the message it completes.
	function automatic void decode_edge(logic active, logic [63:0] stamp);
		logic [63:0] w;
		edge_kind_t  kind;
		int          n;
		int          target;
		int          slot;
		msg_t        m;
		if (active) begin
			last_active_ns = stamp;
			return;
		end
		w = stamp - last_active_ns;   // modulo 2^64
		n = 0;
		if (w >= BIT0_LO && w <= BIT0_HI) begin
			kind = K_BIT0;
		end else if (w >= BIT1_LO && w <= BIT1_HI) begin
			kind = K_BIT1;
		end else begin
			n = sync_bytes(w);
			kind = (n != 0) ? K_SYNC : K_BAD;
		end
		case (kind)
			K_SYNC: begin
				// payload is left alone; every byte sent gets fully shifted over
				msg_len = 3'(n);
				bit_count = 6'd0;
				waiting_sync = 1'b0;
			end
			K_BAD: begin
				drop_message();
			end
			default: begin
				if (!waiting_sync) begin
					target = 8 * int'(msg_len);
					if (int'(bit_count) >= target) begin
						drop_message();
					end else begin
						slot = int'(bit_count) / 8;
						shift_bytes[slot] = {shift_bytes[slot][6:0], kind == K_BIT1};
						bit_count = bit_count + 6'd1;
						if (int'(bit_count) == target) begin
							m.len = msg_len;
							for (int k = 0; k < NUM_BYTES; k++) begin
								m.data[k] = (k < int'(msg_len)) ? shift_bytes[k] : 8'h00;
							end
							pending_msgs.push_back(m);
						end
					end
				end
			end
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------
	function automatic void add_edge(logic active, logic [63:0] stamp);
		edge_t e;
		e.active = active;
		e.stamp = stamp;
		e.drain_first = gen_drain;
		gen_drain = 1'b0;
		edge_queue.push_back(e);
	endfunction

	// Active edge now, release edge one width later; then some idle line time.
	function automatic void add_pulse(logic [63:0] width);
		add_edge(1'b1, gen_now);
		add_edge(1'b0, gen_now + width);
		gen_now = gen_now + width + 64'($urandom_range(0, 3000000));
	endfunction

	// Width that falls outside every class.
	function automatic logic [63:0] bad_width();
		int n;
		n = $urandom_range(1, 4);
		case ($urandom_range(0, 8))
			0: return 64'($urandom_range(0, 299999));
			1: return 64'($urandom_range(700001, 799999));
			2: return 64'($urandom_range(1200001, 1699999));
			// between sync n and sync n+1
			3: return 64'(SYNC_BASE + n * SYNC_STEP - SYNC_TOL - $urandom_range(1, 399999));
			// past the longest sync, where a sixth size would sit
			4: return 64'($urandom_range(6300001, 7300000));
			5: return {$urandom, $urandom};
			6: return 64'd0;
			7: return {32'hFFFF_FFFF, $urandom};   // stamp behind the stored one
			default: begin
				case ($urandom_range(0, 5))
					0: return BIT0_LO - 64'd1;
					1: return BIT0_HI + 64'd1;
					2: return BIT1_LO - 64'd1;
					3: return BIT1_HI + 64'd1;
					4: return 64'(SYNC_BASE - SYNC_TOL - 1);
					default: return 64'(SYNC_BASE + 4 * SYNC_STEP + SYNC_TOL + 1);
				endcase
			end
		endcase
	endfunction

	// Width inside a class, with the window edges hit now and then.
	function automatic logic [63:0] pulse_width(edge_kind_t kind, int sz);
		logic [63:0] lo;
		logic [63:0] hi;
		int          r;
		case (kind)
			K_BIT0: begin
				lo = BIT0_LO;
				hi = BIT0_HI;
			end
			K_BIT1: begin
				lo = BIT1_LO;
				hi = BIT1_HI;
			end
			K_SYNC: begin
				lo = 64'(SYNC_BASE + (sz - 1) * SYNC_STEP - SYNC_TOL);
				hi = lo + 64'(2 * SYNC_TOL);
			end
			default: return bad_width();
		endcase
		r = $urandom_range(0, 7);
		if (r == 0) begin
			return lo;
		end
		if (r == 1) begin
			return hi;
		end
		return lo + 64'($urandom_range(0, 32'(hi - lo)));
	endfunction

	function automatic edge_kind_t any_bit();
		return ($urandom_range(0, 1) != 0) ? K_BIT1 : K_BIT0;
	endfunction

	function automatic void compare_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
			errors++;
		end
	endfunction

	// ---------------------------------------------------------------------
	// Driver: one edge transaction per accepted handshake. Payload only
	// moves when the current transaction is gone or nothing is offered.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			line_active <= 1'b0;
			edge_time_ns <= 64'd0;
			gap_left <= 0;
			edges_accepted <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				decode_edge(line_active, edge_time_ns);
				edges_accepted <= edges_accepted + 1;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (edge_queue.size() != 0 &&
					!(edge_queue[0].drain_first && pending_msgs.size() != 0)) begin
					next_edge = edge_queue.pop_front();
					in_valid <= 1'b1;
					line_active <= next_edge.active;
					edge_time_ns <= next_edge.stamp;
					if (may_idle && $urandom_range(0, 15) == 0) begin
						gap_left <= $urandom_range(1, 19);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Output stall: random bursts, plus one long hold-off
	// while the driver keeps offering, so the edge queue fills and in_stall
	// must rise.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			long_hold_done <= 1'b0;
		end else if (!long_hold_done && edges_accepted >= 400) begin
			long_hold_done <= 1'b1;
			stall_left <= 300;
			out_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (may_idle && $urandom_range(0, 11) == 0) begin
			stall_left <= $urandom_range(0, 18);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: every message transaction against the oldest prediction.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_msgs.size() == 0) begin
				$display("%0t: unexpected message, expected none, actual size %0d bytes %h %h %h %h %h",
					$time, msg_size, byte0, byte1, byte2, byte3, byte4);
				errors++;
			end else begin
				want = pending_msgs.pop_front();
				compare_field("msg_size", want.len, msg_size);
				compare_field("byte0", want.data[0], byte0);
				compare_field("byte1", want.data[1], byte1);
				compare_field("byte2", want.data[2], byte2);
				compare_field("byte3", want.data[3], byte3);
				compare_field("byte4", want.data[4], byte4);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus and end of test
	// ---------------------------------------------------------------------
	initial begin
		logic [63:0] corner_widths [8];
		int          pick;
		int          len;
		int          cut;
		logic        drain_marked;

		// Directed part.
		// Release with no active edge since reset: width counts from the
		// cleared stamp, lands as a 1 bit while idle and is ignored.
		add_edge(1'b0, 64'd1000000);
		// One-byte sync straddling the 2^64 wrap of the timestamp.
		gen_now = 64'hFFFF_FFFF_FFF0_0000;
		add_pulse(64'(SYNC_BASE));
		add_pulse(BIT1_HI);
		// New sync in the middle of the message, at the lowest sync width.
		add_pulse(64'(SYNC_BASE - SYNC_TOL));
		// Full byte on the bit window edges: 0011_0101.
		corner_widths = '{BIT0_LO, BIT0_HI, BIT1_LO, BIT1_HI,
			BIT0_LO, BIT1_HI, BIT0_HI, BIT1_LO};
		foreach (corner_widths[i]) begin
			add_pulse(corner_widths[i]);
		end
		// A bit after the message is complete drops the receiver to idle.
		add_pulse(BIT0_HI);

		// Random part: mostly well-formed messages with random content.
		drain_marked = 1'b0;
		while (edge_queue.size() < 1275 || clean_msgs < 40) begin
			if (!drain_marked && edge_queue.size() >= 650) begin
				// sender waits here for all results to come out
				drain_marked = 1'b1;
				gen_drain = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				if ($urandom_range(0, 3) == 0) begin
					gen_now = {$urandom, $urandom};
				end
				len = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 2) : $urandom_range(3, 5);
				// some messages break off; the next sync then restarts mid-message
				cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8 * len - 1) : 8 * len;
				add_pulse(pulse_width(K_SYNC, len));
				for (int i = 0; i < cut; i++) begin
					add_pulse(pulse_width(any_bit(), 0));
				end
				if (cut < 8 * len) begin
					if ($urandom_range(0, 1) != 0) begin
						add_pulse(bad_width());
					end
				end else begin
					clean_msgs++;
					if ($urandom_range(0, 4) == 0) begin
						add_pulse(pulse_width(any_bit(), 0));
					end
				end
			end else if (pick < 88) begin
				// stray bits, mostly while idle
				repeat ($urandom_range(1, 4)) begin
					add_pulse(pulse_width(any_bit(), 0));
				end
			end else if (pick < 94) begin
				add_pulse(bad_width());
			end else begin
				// lone edge: doubled active, or release against an old stamp
				add_edge($urandom_range(0, 1) != 0, {$urandom, $urandom});
			end
		end
		total_edges = edge_queue.size();
		calm_from = total_edges - 150;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		wait (edges_accepted == total_edges);
		for (int i = 0; i < 20000 && pending_msgs.size() != 0; i++) begin
			@(posedge clk);
		end
		// then wait on to catch any stray message
		repeat (10) @(posedge clk);
		if (pending_msgs.size() != 0) begin
			$display("%0t: %0d messages expected, actual none", $time, pending_msgs.size());
			errors++;
		end
		if (errors == 0) begin
			$display("pulse_length_line_receiver_test: PASS");
		end else begin
			$display("pulse_length_line_receiver_test: FAIL");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#5000000;
		$display("%0t: timeout", $time);
		$display("pulse_length_line_receiver_test: FAIL");
		$finish;
	end

endmodule
